>>> src/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Shared constants, codes, types and helpers of the call stack profiler.
// ----------------------------------------------------------------------------
`default_nettype none
package csp_pkg;

    localparam int FUNC_BITS       = 4;
    localparam int FUNC_COUNT      = 1 << FUNC_BITS;
    localparam int PAIR_COUNT      = FUNC_COUNT * FUNC_COUNT;
    localparam int PAIR_BITS       = 2 * FUNC_BITS;
    localparam int STACK_DEPTH     = 64;
    localparam int STACK_ADDR_BITS = 6;
    localparam int SP_BITS         = 7;
    localparam int TIME_BITS       = 48;
    localparam int CNT_BITS        = 32;
    localparam int SUM_BITS        = 64;
    localparam int REC_BITS        = 7;
    localparam int ACT_BITS        = 3;
    localparam int STAT_BITS       = 2;
    localparam int STACK_W         = FUNC_BITS + TIME_BITS;
    localparam int IN_DATA_W       = 56;
    localparam int OUT_DATA_W      = 352;

    // event kinds
    localparam logic [ACT_BITS-1:0] ACT_ENTER     = 3'd0;
    localparam logic [ACT_BITS-1:0] ACT_EXIT      = 3'd1;
    localparam logic [ACT_BITS-1:0] ACT_SUSPEND   = 3'd2;
    localparam logic [ACT_BITS-1:0] ACT_RESUME    = 3'd3;
    localparam logic [ACT_BITS-1:0] ACT_READ_FUNC = 3'd4;
    localparam logic [ACT_BITS-1:0] ACT_READ_PAIR = 3'd5;

    // result status
    localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [REC_BITS-1:0] rec;
        logic [CNT_BITS-1:0] calls;
        logic [SUM_BITS-1:0] direct;
        logic [SUM_BITS-1:0] recur;
    } stat_t;

    typedef struct packed {
        stat_t               st;
        logic [SUM_BITS-1:0] susp;
    } func_ent_t;

    typedef struct packed {
        logic load_in;
        logic rd_top;
        logic rd_next;
        logic rd_pair;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

    // count one more call, saturating
    function automatic stat_t stat_enter(input stat_t s);
        stat_t r;
        r = s;
        r.rec = s.rec + REC_BITS'(1);
        if (s.calls != {CNT_BITS{1'b1}})
        begin
            r.calls = s.calls + CNT_BITS'(1);
        end
        return r;
    endfunction

    // book one exit: direct at the outermost activation, else recursive
    function automatic stat_t stat_exit(input stat_t s, input logic [TIME_BITS-1:0] el);
        stat_t r;
        r = s;
        if (s.rec != '0)
        begin
            r.rec = s.rec - REC_BITS'(1);
        end
        if (r.rec == '0)
        begin
            r.direct = s.direct + SUM_BITS'(el);
        end
        else
        begin
            r.recur = s.recur + SUM_BITS'(el);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/csp_ram.sv
// ----------------------------------------------------------------------------
// csp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module csp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> src/csp_ctrl.sv
// ----------------------------------------------------------------------------
// csp_ctrl
// Sequencer for one profiler event: stack reads, pair read, commit.
// ----------------------------------------------------------------------------
`default_nettype none
module csp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire csp_pkg::sts_t sts,
    output csp_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TOP    = 3'd1;
    localparam logic [2:0] S_NEXT   = 3'd2;
    localparam logic [2:0] S_PAIR   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // step through the event
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                cmd.rd_top = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                cmd.rd_next = 1'b1;
                state_next  = S_PAIR;
            end
            S_PAIR:
            begin
                cmd.rd_pair = 1'b1;
                state_next  = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("commit while output register busy");
    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> in_ready)
        else $error("not idle after commit");
    a_load_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> cmd.rd_top)
        else $error("stack read did not follow accept");
`endif

endmodule
`default_nettype wire

>>> src/csp_dp.sv
// ----------------------------------------------------------------------------
// csp_dp
// Datapath: call stack RAM, function table, pair table RAM, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module csp_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire csp_pkg::cmd_t                     cmd,
    output csp_pkg::sts_t                          sts,
    input  wire logic [csp_pkg::ACT_BITS-1:0]      in_user,
    input  wire logic [csp_pkg::IN_DATA_W-1:0]     in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [csp_pkg::OUT_DATA_W-1:0]    out_data,
    output logic      [csp_pkg::STAT_BITS-1:0]     out_user
);

    localparam int FB = csp_pkg::FUNC_BITS;
    localparam int TB = csp_pkg::TIME_BITS;
    localparam int SB = csp_pkg::SP_BITS;
    localparam int AB = csp_pkg::STACK_ADDR_BITS;
    localparam int PB = csp_pkg::PAIR_BITS;
    localparam int SU = csp_pkg::SUM_BITS;

    // latched event
    logic [csp_pkg::ACT_BITS-1:0] act_reg;
    logic [FB-1:0]                fid_reg;
    logic [FB-1:0]                cid_reg;
    logic [TB-1:0]                time_reg;

    // architectural state
    logic [SB-1:0]        sp_reg;
    logic [TB-1:0]        susp_start_reg;
    logic [SU-1:0]        thread_sum_reg;
    csp_pkg::func_ent_t   func_tab_reg [csp_pkg::FUNC_COUNT];
    logic [csp_pkg::PAIR_COUNT-1:0] pair_vld_reg;

    // per-event scratch
    logic [FB-1:0]        top_fid_reg;
    logic [TB-1:0]        top_time_reg;
    logic [PB-1:0]        pair_addr_reg;
    logic [PB-1:0]        pair_addr_next;

    // output register
    logic                              out_valid_reg;
    logic [csp_pkg::OUT_DATA_W-1:0]    out_data_reg;
    logic [csp_pkg::STAT_BITS-1:0]     out_user_reg;

    // stack RAM
    logic                             stk_wr_en;
    logic [AB-1:0]                    stk_rd_addr;
    logic [csp_pkg::STACK_W-1:0]      stk_rd_data;

    // pair RAM
    logic                             pair_wr_en;
    logic [$bits(csp_pkg::stat_t)-1:0] pair_rd_raw;
    csp_pkg::stat_t                   pair_cur;
    csp_pkg::stat_t                   pair_new;

    // commit results
    csp_pkg::func_ent_t           func_cur;
    csp_pkg::func_ent_t           func_new;
    logic [FB-1:0]                func_idx;
    logic                         func_wr;
    logic [SB-1:0]                sp_new;
    logic [TB-1:0]                el;
    logic [TB-1:0]                el_out;
    logic [SU-1:0]                thread_new;
    logic [csp_pkg::STAT_BITS-1:0] status;
    logic [csp_pkg::CNT_BITS-1:0] r_calls;
    logic [csp_pkg::REC_BITS-1:0] r_depth;
    logic [SU-1:0]                r_direct;
    logic [SU-1:0]                r_recur;
    logic [SU-1:0]                r_susp;
    logic                         sp_empty;
    logic                         sp_full;

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;
    assign out_user     = out_user_reg;
    assign sp_empty     = (sp_reg == '0);
    assign sp_full      = (sp_reg == SB'(csp_pkg::STACK_DEPTH));

    // stack read at top, then one below top
    assign stk_rd_addr = cmd.rd_top ? AB'(sp_reg - SB'(1)) : AB'(sp_reg - SB'(2));

    csp_ram #(
        .WIDTH (csp_pkg::STACK_W),
        .DEPTH (csp_pkg::STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (sp_reg[AB-1:0]),
        .wr_data ({fid_reg, time_reg}),
        .rd_en   (cmd.rd_top || cmd.rd_next),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // pick the pair entry touched by this event
    always_comb
    begin
        unique case (act_reg)
            csp_pkg::ACT_ENTER:     pair_addr_next = {top_fid_reg, fid_reg};
            csp_pkg::ACT_EXIT:      pair_addr_next = {stk_rd_data[csp_pkg::STACK_W-1 -: FB],
                                                      top_fid_reg};
            default:                pair_addr_next = {cid_reg, fid_reg};
        endcase
    end

    csp_ram #(
        .WIDTH ($bits(csp_pkg::stat_t)),
        .DEPTH (csp_pkg::PAIR_COUNT)
    ) u_pair (
        .clk     (clk),
        .wr_en   (pair_wr_en),
        .wr_addr (pair_addr_reg),
        .wr_data (pair_new),
        .rd_en   (cmd.rd_pair),
        .rd_addr (pair_addr_next),
        .rd_data (pair_rd_raw)
    );

    // never-written pair entries read as zero
    assign pair_cur = pair_vld_reg[pair_addr_reg] ? csp_pkg::stat_t'(pair_rd_raw) : '0;

    // compute the event's effect
    always_comb
    begin
        func_idx   = fid_reg;
        func_wr    = 1'b0;
        stk_wr_en  = 1'b0;
        pair_wr_en = 1'b0;
        sp_new     = sp_reg;
        thread_new = thread_sum_reg;
        status     = csp_pkg::ST_OK;
        el         = time_reg - top_time_reg;
        el_out     = '0;
        r_calls    = '0;
        r_depth    = '0;
        r_direct   = '0;
        r_recur    = '0;
        r_susp     = '0;
        pair_new   = pair_cur;
        if (act_reg == csp_pkg::ACT_EXIT || act_reg == csp_pkg::ACT_RESUME)
        begin
            func_idx = top_fid_reg;
        end
        func_cur = func_tab_reg[func_idx];
        func_new = func_cur;
        unique case (act_reg)
            csp_pkg::ACT_ENTER:
            begin
                if (sp_full)
                begin
                    status = csp_pkg::ST_FULL;
                end
                else
                begin
                    func_new.st = csp_pkg::stat_enter(func_cur.st);
                    func_wr     = 1'b1;
                    stk_wr_en   = cmd.commit;
                    pair_new    = csp_pkg::stat_enter(pair_cur);
                    pair_wr_en  = cmd.commit && !sp_empty;
                    sp_new      = sp_reg + SB'(1);
                end
            end
            csp_pkg::ACT_EXIT:
            begin
                if (sp_empty)
                begin
                    status = csp_pkg::ST_EMPTY;
                end
                else
                begin
                    func_new.st = csp_pkg::stat_exit(func_cur.st, el);
                    func_wr     = 1'b1;
                    pair_new    = csp_pkg::stat_exit(pair_cur, el);
                    pair_wr_en  = cmd.commit && (sp_reg > SB'(1));
                    sp_new      = sp_reg - SB'(1);
                    el_out      = el;
                end
            end
            csp_pkg::ACT_SUSPEND:
            begin
                if (sp_empty)
                begin
                    status = csp_pkg::ST_EMPTY;
                end
            end
            csp_pkg::ACT_RESUME:
            begin
                if (sp_empty)
                begin
                    status = csp_pkg::ST_EMPTY;
                end
                else
                begin
                    el_out        = time_reg - susp_start_reg;
                    func_new.susp = func_cur.susp + SU'(el_out);
                    func_wr       = 1'b1;
                    thread_new    = thread_sum_reg + SU'(el_out);
                end
            end
            csp_pkg::ACT_READ_FUNC:
            begin
                r_calls  = func_cur.st.calls;
                r_depth  = func_cur.st.rec;
                r_direct = func_cur.st.direct;
                r_recur  = func_cur.st.recur;
                r_susp   = func_cur.susp;
            end
            csp_pkg::ACT_READ_PAIR:
            begin
                r_calls  = pair_cur.calls;
                r_depth  = pair_cur.rec;
                r_direct = pair_cur.direct;
                r_recur  = pair_cur.recur;
            end
            default:
            begin
            end
        endcase
    end

    // apply commit to the architectural state and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg         <= '0;
            susp_start_reg <= '0;
            thread_sum_reg <= '0;
            pair_vld_reg   <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < csp_pkg::FUNC_COUNT; i++)
            begin
                func_tab_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.commit)
            begin
                sp_reg         <= sp_new;
                thread_sum_reg <= thread_new;
                out_valid_reg  <= 1'b1;
                if (act_reg == csp_pkg::ACT_SUSPEND)
                begin
                    susp_start_reg <= time_reg;
                end
                if (func_wr)
                begin
                    func_tab_reg[func_idx] <= func_new;
                end
                if (pair_wr_en)
                begin
                    pair_vld_reg[pair_addr_reg] <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg  <= in_user;
            fid_reg  <= in_data[FB-1:0];
            cid_reg  <= in_data[2*FB-1:FB];
            time_reg <= in_data[2*FB +: TB];
        end
        if (cmd.rd_next)
        begin
            top_fid_reg  <= stk_rd_data[csp_pkg::STACK_W-1 -: FB];
            top_time_reg <= stk_rd_data[TB-1:0];
        end
        if (cmd.rd_pair)
        begin
            pair_addr_reg <= pair_addr_next;
        end
        if (cmd.commit)
        begin
            out_user_reg <= status;
            out_data_reg <= {2'b00, sp_new, thread_new, r_susp, r_recur, r_direct,
                             r_depth, r_calls, el_out};
        end
    end

`ifndef SYNTH
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SB'(csp_pkg::STACK_DEPTH))
        else $error("stack pointer beyond depth");
    a_sp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.commit) |-> $stable(sp_reg))
        else $error("stack pointer moved outside commit");
    a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result not presented after commit");
`endif

endmodule
`default_nettype wire

>>> src/call_stack_cycle_profiler.sv
// ----------------------------------------------------------------------------
// call_stack_cycle_profiler
// Call stack profiler: per-function and caller-callee cycle statistics.
// ----------------------------------------------------------------------------
// Each event beat on s_axis produces exactly one result beat on m_axis. One
// event is processed at a time: after acceptance it passes two reads of the
// call stack RAM through its single read port, one read of the pair table RAM
// and one commit into the result register; the commit waits while the result
// register is still full and m_axis does not take it. The sequencer then
// returns to idle, where it can accept the next event. A finished result
// waits in its own register; the next event is accepted while it waits.
// No clearing pass is needed after reset: the pair table is tracked by
// per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none
module call_stack_cycle_profiler (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // function_id[3:0], caller_id[7:4], cycle_time[55:8]
    input  wire logic [55:0]  s_axis_tdata,
    // action[2:0]
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // elapsed[47:0], call_count[79:48], active_depth[86:80],
    // direct_cycles[150:87], recursive_cycles[214:151],
    // suspended_cycles[278:215], thread_suspended_total[342:279],
    // stack_depth[349:343], zero[351:350]
    output logic      [351:0] m_axis_tdata,
    // status[1:0]
    output logic      [1:0]   m_axis_tuser
);

    csp_pkg::cmd_t cmd;
    csp_pkg::sts_t sts;

    csp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    csp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_user   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule
`default_nettype wire
